// File: sv/urh_pkg.sv
// ----------------------------------------------------------------------------
// urh_pkg: shared types and codes for the undo/redo history ring
// Request and action codes, datapath micro-ops, controller/datapath bundles.
// ----------------------------------------------------------------------------
package urh_pkg;

  // Request codes (req_type)
  localparam logic [2:0] REQ_PUSH   = 3'd0;
  localparam logic [2:0] REQ_POP    = 3'd1;
  localparam logic [2:0] REQ_UNDO   = 3'd2;
  localparam logic [2:0] REQ_REDO   = 3'd3;
  localparam logic [2:0] REQ_COMMIT = 3'd4;

  // Action codes (action)
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_REVERT  = 2'd2;
  localparam logic [1:0] ACT_REAPPLY = 2'd3;

  // Status codes
  localparam logic STS_OK        = 1'b0;
  localparam logic STS_POP_EMPTY = 1'b1;

  // Ring geometry: indices never exceed 63, counts reach 64
  localparam int MAX_SLOTS = 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_RD_NEWEST,
    DP_RD_OLDEST,
    DP_RD_UNDO,
    DP_RD_REDO,
    DP_DROP,
    DP_EVICT,
    DP_STORE,
    DP_UNDO,
    DP_REDO
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   end_undo;  // leave undo mode
    logic   emit;      // load the result register
    logic   last;
    logic   err;       // pop on empty history
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic undone_zero;
    logic undone_one;
    logic undo_ok;
    logic out_free;
  } stat_t;

endpackage

// File: sv/urh_req_if.sv
// ----------------------------------------------------------------------------
// urh_req_if: request channel of the history ring
// valid/ready handshake carrying request type and action handle.
// ----------------------------------------------------------------------------
interface urh_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] entry_handle;

  modport source (output valid, output req_type, output entry_handle, input ready);
  modport sink   (input valid, input req_type, input entry_handle, output ready);
endinterface

// File: sv/urh_res_if.sv
// ----------------------------------------------------------------------------
// urh_res_if: result channel of the history ring
// valid/ready handshake carrying one result item per transfer.
// ----------------------------------------------------------------------------
interface urh_res_if;
  logic               valid;
  logic               ready;
  logic [31:0]        handle_out;
  logic [1:0]         action;
  logic               status;
  logic               last;
  logic [6:0]         undo_avail;
  logic [6:0]         redo_avail;
  logic signed [31:0] change_count;

  modport source (output valid, output handle_out, output action, output status,
                  output last, output undo_avail, output redo_avail,
                  output change_count, input ready);
  modport sink   (input valid, input handle_out, input action, input status,
                  input last, input undo_avail, input redo_avail,
                  input change_count, output ready);
endinterface

// File: sv/urh_ram.sv
// ----------------------------------------------------------------------------
// urh_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module urh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/urh_datapath.sv
// ----------------------------------------------------------------------------
// urh_datapath: ring pointers, counters, slot memory and result register
// Executes one micro-op per cycle as commanded by the controller.
// ----------------------------------------------------------------------------
module urh_datapath #(
  parameter int DEPTH    = 64,
  parameter int HANDLE_W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  urh_pkg::cmd_t       cmd_i,
  output urh_pkg::stat_t      stat_o,
  input  logic [31:0]         entry_handle_i,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_data_i,
  urh_res_if.source           res_o
);

  localparam int SLOTS = (DEPTH < urh_pkg::MAX_SLOTS) ? DEPTH : urh_pkg::MAX_SLOTS;
  localparam int AW    = $clog2(SLOTS);
  localparam int IW    = urh_pkg::IDX_W;
  localparam int CW    = urh_pkg::CNT_W;

  function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i, input logic [CW-1:0] ce);
    return (({1'b0, i} + CW'(1)) >= ce) ? '0 : i + IW'(1);
  endfunction

  function automatic logic [IW-1:0] prv(input logic [IW-1:0] i, input logic [CW-1:0] ce);
    return (i == '0) ? IW'(ce - CW'(1)) : i - IW'(1);
  endfunction

  // control state
  logic [IW-1:0] newest_q, newest_d, oldest_q, oldest_d, cursor_q, cursor_d;
  logic [CW-1:0] count_q, count_d, undone_q, undone_d, cap_q, cap_d;
  logic          active_q, active_d;
  logic [31:0]   modif_q, modif_d;
  logic          out_valid_q, out_valid_d;
  // payload
  logic [HANDLE_W-1:0] handle_q;
  logic [31:0]         out_handle_q, out_handle_d;
  logic [1:0]          out_action_q, out_action_d;
  logic                out_status_q, out_last_q;
  logic [CW-1:0]       out_undo_q, out_redo_q;
  logic [31:0]         out_change_q;

  // memory port
  logic                ram_we, ram_re;
  logic [IW-1:0]       waddr_idx, raddr_idx;
  logic [HANDLE_W-1:0] rdata;
  logic [IW-1:0]       cur_eff, nn;
  logic [CW-1:0]       undone_eff, cfg_cap;

  urh_ram #(.WIDTH(HANDLE_W), .DEPTH(SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(waddr_idx)),
    .wdata_i (handle_q),
    .re_i    (ram_re),
    .raddr_i (AW'(raddr_idx)),
    .rdata_o (rdata)
  );

  // clamp of a written capacity to 1..SLOTS
  always_comb begin
    cfg_cap = cfg_data_i;
    if (cfg_cap == '0) begin
      cfg_cap = CW'(1);
    end else if (cfg_cap > CW'(SLOTS)) begin
      cfg_cap = CW'(SLOTS);
    end
  end

  always_comb begin
    cur_eff    = active_q ? cursor_q : newest_q;
    undone_eff = active_q ? undone_q : '0;
    newest_d   = newest_q;
    oldest_d   = oldest_q;
    cursor_d   = cursor_q;
    count_d    = count_q;
    undone_d   = undone_q;
    active_d   = active_q;
    modif_d    = modif_q;
    cap_d      = cap_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    waddr_idx  = oldest_q;
    raddr_idx  = newest_q;
    nn         = prv(newest_q, cap_q);
    out_handle_d = '0;
    out_action_d = urh_pkg::ACT_NONE;

    unique case (cmd_i.op)
      urh_pkg::DP_RD_NEWEST: begin
        ram_re = 1'b1;
      end
      urh_pkg::DP_RD_OLDEST: begin
        ram_re    = 1'b1;
        raddr_idx = oldest_q;
      end
      urh_pkg::DP_RD_UNDO: begin
        ram_re    = 1'b1;
        raddr_idx = cur_eff;
      end
      urh_pkg::DP_RD_REDO: begin
        ram_re    = 1'b1;
        raddr_idx = nxt(cursor_q, cap_q);
      end
      urh_pkg::DP_DROP: begin
        newest_d = nn;
        count_d  = count_q - CW'(1);
        if (undone_q != '0) begin
          undone_d = undone_q - CW'(1);
        end else if (active_q) begin
          cursor_d = nn;
        end
        out_handle_d = 32'(rdata);
        out_action_d = urh_pkg::ACT_RELEASE;
      end
      urh_pkg::DP_EVICT: begin
        // a push always leaves undo mode, eviction or not
        ram_we   = 1'b1;
        active_d = 1'b0;
        newest_d = oldest_q;
        oldest_d = nxt(oldest_q, cap_q);
        modif_d  = modif_q + 32'd1;
        out_handle_d = 32'(rdata);
        out_action_d = urh_pkg::ACT_RELEASE;
      end
      urh_pkg::DP_STORE: begin
        ram_we   = 1'b1;
        active_d = 1'b0;
        modif_d  = modif_q + 32'd1;
        if (count_q == '0) begin
          waddr_idx = '0;
          newest_d  = '0;
          oldest_d  = '0;
          count_d   = CW'(1);
        end else begin
          waddr_idx = nxt(newest_q, cap_q);
          newest_d  = waddr_idx;
          count_d   = count_q + CW'(1);
        end
      end
      urh_pkg::DP_UNDO: begin
        cursor_d = prv(cur_eff, cap_q);
        active_d = 1'b1;
        undone_d = undone_eff + CW'(1);
        modif_d  = modif_q - 32'd1;
        out_handle_d = 32'(rdata);
        out_action_d = urh_pkg::ACT_REVERT;
      end
      urh_pkg::DP_REDO: begin
        cursor_d = nxt(cursor_q, cap_q);
        undone_d = undone_q - CW'(1);
        modif_d  = modif_q + 32'd1;
        out_handle_d = 32'(rdata);
        out_action_d = urh_pkg::ACT_REAPPLY;
      end
      default: begin
      end
    endcase

    if (cmd_i.end_undo) begin
      active_d = 1'b0;
    end
    // history emptied: back to the reset arrangement
    if (count_d == '0) begin
      newest_d = '0;
      oldest_d = '0;
      cursor_d = '0;
      undone_d = '0;
      active_d = 1'b0;
    end
    // capacity write empties the ring without releases
    if (cfg_we_i) begin
      cap_d    = cfg_cap;
      newest_d = '0;
      oldest_d = '0;
      cursor_d = '0;
      count_d  = '0;
      undone_d = '0;
      active_d = 1'b0;
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q    <= '0;
      oldest_q    <= '0;
      cursor_q    <= '0;
      count_q     <= '0;
      undone_q    <= '0;
      active_q    <= 1'b0;
      modif_q     <= '0;
      cap_q       <= CW'(SLOTS);
      out_valid_q <= 1'b0;
    end else begin
      newest_q    <= newest_d;
      oldest_q    <= oldest_d;
      cursor_q    <= cursor_d;
      count_q     <= count_d;
      undone_q    <= undone_d;
      active_q    <= active_d;
      modif_q     <= modif_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == urh_pkg::DP_LOAD) begin
      handle_q <= HANDLE_W'(entry_handle_i);
    end
    if (cmd_i.emit) begin
      out_handle_q <= out_handle_d;
      out_action_q <= out_action_d;
      out_status_q <= cmd_i.err ? urh_pkg::STS_POP_EMPTY : urh_pkg::STS_OK;
      out_last_q   <= cmd_i.last;
      out_undo_q   <= count_d - undone_d;
      out_redo_q   <= undone_d;
      out_change_q <= modif_d;
    end
  end

  assign stat_o.empty       = (count_q == '0);
  assign stat_o.full        = (count_q >= cap_q);
  assign stat_o.undone_zero = (undone_q == '0);
  assign stat_o.undone_one  = (undone_q == CW'(1));
  assign stat_o.undo_ok     = (count_q != '0) && (!active_q || (undone_q < count_q));
  assign stat_o.out_free    = !out_valid_q || res_o.ready;

  assign res_o.valid        = out_valid_q;
  assign res_o.handle_out   = out_handle_q;
  assign res_o.action       = out_action_q;
  assign res_o.status       = out_status_q;
  assign res_o.last         = out_last_q;
  assign res_o.undo_avail   = out_undo_q;
  assign res_o.redo_avail   = out_redo_q;
  assign res_o.change_count = $signed(out_change_q);

  a_undone_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    undone_q <= count_q)
    else $error("undone entries exceed stored entries");

  a_count_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("entry count above capacity");

  a_undone_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (undone_q == '0))
    else $error("undone entries outside undo mode");

endmodule

// File: sv/urh_ctrl.sv
// ----------------------------------------------------------------------------
// urh_ctrl: request sequencer of the history ring
// Walks each request through slot reads, releases and result emission.
// ----------------------------------------------------------------------------
module urh_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic [2:0]     req_type_i,
  output logic           req_ready_o,
  input  urh_pkg::stat_t stat_i,
  output urh_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DROP,
    S_EVICT,
    S_UNDO,
    S_REDO
  } state_e;

  state_e        state_q, state_d;
  logic [2:0]    req_q, req_d;
  logic          emitted_q, emitted_d;
  logic          in_fire;
  urh_pkg::cmd_t cmd;

  assign req_ready_o = (state_q == S_IDLE);
  assign in_fire     = req_valid_i && req_ready_o;

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    cmd.op       = urh_pkg::DP_NOP;
    cmd.end_undo = 1'b0;
    cmd.emit     = 1'b0;
    cmd.last     = 1'b0;
    cmd.err      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          req_d   = req_type_i;
          cmd.op  = urh_pkg::DP_LOAD;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (req_q)
          urh_pkg::REQ_PUSH: begin
            if (!stat_i.undone_zero) begin
              cmd.op  = urh_pkg::DP_RD_NEWEST;
              state_d = S_DROP;
            end else if (stat_i.full && !stat_i.empty) begin
              cmd.op  = urh_pkg::DP_RD_OLDEST;
              state_d = S_EVICT;
            end else if (emitted_q || stat_i.out_free) begin
              // a store after releases adds no result of its own
              cmd.op   = urh_pkg::DP_STORE;
              cmd.emit = !emitted_q;
              cmd.last = 1'b1;
              state_d  = S_IDLE;
            end
          end
          urh_pkg::REQ_POP: begin
            if (!stat_i.empty) begin
              cmd.op  = urh_pkg::DP_RD_NEWEST;
              state_d = S_DROP;
            end else if (stat_i.out_free) begin
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
              cmd.err  = 1'b1;
              state_d  = S_IDLE;
            end
          end
          urh_pkg::REQ_UNDO: begin
            if (stat_i.undo_ok) begin
              cmd.op  = urh_pkg::DP_RD_UNDO;
              state_d = S_UNDO;
            end else if (stat_i.out_free) begin
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
              state_d  = S_IDLE;
            end
          end
          urh_pkg::REQ_REDO: begin
            if (!stat_i.undone_zero) begin
              cmd.op  = urh_pkg::DP_RD_REDO;
              state_d = S_REDO;
            end else if (stat_i.out_free) begin
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
              state_d  = S_IDLE;
            end
          end
          urh_pkg::REQ_COMMIT: begin
            if (!stat_i.undone_zero) begin
              cmd.op  = urh_pkg::DP_RD_NEWEST;
              state_d = S_DROP;
            end else if (stat_i.out_free) begin
              cmd.end_undo = 1'b1;
              cmd.emit     = 1'b1;
              cmd.last     = 1'b1;
              state_d      = S_IDLE;
            end
          end
          default: begin
            if (stat_i.out_free) begin
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
              state_d  = S_IDLE;
            end
          end
        endcase
      end
      S_DROP: begin
        if (stat_i.out_free) begin
          cmd.op   = urh_pkg::DP_DROP;
          cmd.emit = 1'b1;
          if (req_q == urh_pkg::REQ_POP) begin
            cmd.last = 1'b1;
            state_d  = S_IDLE;
          end else if (stat_i.undone_one) begin
            // final undone entry: leave undo mode; a push still stores
            cmd.last     = 1'b1;
            cmd.end_undo = 1'b1;
            state_d      = (req_q == urh_pkg::REQ_PUSH) ? S_DECIDE : S_IDLE;
          end else begin
            state_d = S_DECIDE;
          end
        end
      end
      S_EVICT: begin
        if (stat_i.out_free) begin
          cmd.op   = urh_pkg::DP_EVICT;
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_UNDO: begin
        if (stat_i.out_free) begin
          cmd.op   = urh_pkg::DP_UNDO;
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_REDO: begin
        if (stat_i.out_free) begin
          cmd.op   = urh_pkg::DP_REDO;
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    emitted_d = in_fire ? 1'b0 : (emitted_q | cmd.emit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      req_q     <= urh_pkg::REQ_PUSH;
      emitted_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      req_q     <= req_d;
      emitted_q <= emitted_d;
    end
  end

  assign cmd_o = cmd;

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> stat_i.out_free)
    else $error("result loaded while output register is occupied");

  a_accept_to_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_DECIDE))
    else $error("accepted request not decoded next cycle");

  a_last_ends_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && cmd.last && (state_q != S_DROP)) |=> (state_q == S_IDLE))
    else $error("final result emitted but request still in progress");

endmodule

// File: sv/undo_redo_history_ring_top.sv
// ----------------------------------------------------------------------------
// undo_redo_history_ring_top: undo/redo history ring of action handles
// Requests push, pop, undo, redo and commit on a ring of up to 64 handles.
// ----------------------------------------------------------------------------
// Usage:
//  - req_i carries one request per transfer (req_type, entry_handle).
//    res_o returns one or more results per request; the final one has last.
//  - cfg_we_i/cfg_data_i write the capacity; the user must write only while
//    the block is idle, which the block itself does not enforce. A write
//    empties the ring without releasing handles. The change count is kept.
//  - Requests are handled one at a time. req_i.ready is high only while the
//    sequencer is idle; a new request is taken even while the previous final
//    result still waits in the output register.
//  - Steps: a request with no slot read (none result, pop on empty, plain
//    store) is finished in S_DECIDE; undo, redo, pop and eviction first read
//    the slot RAM, whose read is registered, and then act on the read handle.
//    Commit, and a push over undone entries, read and then release each
//    undone entry in turn; a push then adds its store.
//  - Reset clears pointers, counts and the change count and sets capacity
//    to min(DEPTH, 64). Slot contents are not cleared: only occupied slots
//    are ever read.
//  - When res_o.ready is low the result is held and the sequencer waits in
//    its current step until the output register frees up.
// ----------------------------------------------------------------------------
module undo_redo_history_ring_top #(
  parameter int DEPTH    = 64,
  parameter int HANDLE_W = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  urh_req_if.sink    req_i,
  urh_res_if.source  res_o,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_data_i
);

  // controller/datapath bundles
  urh_pkg::cmd_t  cmd;
  urh_pkg::stat_t stat;

  // Sequencer: decodes the request and issues one datapath micro-op a cycle.
  urh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: ring indices, counters, slot RAM and the result register.
  urh_datapath #(
    .DEPTH    (DEPTH),
    .HANDLE_W (HANDLE_W)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .entry_handle_i (req_i.entry_handle),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .res_o          (res_o)
  );

endmodule
